// ===== rtl/core/tswr_pkg.sv =====
// shared types and constants of the tcp sender window/retransmit core
package tswr_pkg;

    localparam int MAX_PAYLOAD_DEF = 1452;
    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int STREAM_CAP_DEF  = 65536;
    localparam int MAX_RESULTS     = 16;

    localparam logic [15:0] INIT_RTO_RESET = 16'd1000;

    // operation codes
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_END   = 3'd1;
    localparam logic [2:0] OP_FILL  = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;
    localparam logic [2:0] OP_EMPTY = 3'd5;

    // result kinds
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_NEW    = 2'd1;
    localparam logic [1:0] KIND_RETX   = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_ISN = 2'd0;
    localparam logic [1:0] CFG_RTO = 2'd1;

    // one outstanding segment
    typedef struct packed {
        logic [63:0] start;
        logic [10:0] len;
        logic        syn;
        logic        fin;
    } qentry_t;

endpackage

// ===== rtl/core/tswr_if.sv =====
// channel interfaces for input events and result descriptors
interface tswr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] byte_count;
    logic [31:0] ackno;
    logic [15:0] adv_window;
    logic [15:0] elapsed_ms;

    modport source (output valid, op, byte_count, ackno, adv_window, elapsed_ms,
                    input ready);
    modport sink   (input valid, op, byte_count, ackno, adv_window, elapsed_ms,
                    output ready);
endinterface

interface tswr_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] seqno;
    logic [10:0] payload_length;
    logic [63:0] stream_offset;
    logic        syn_flag;
    logic        fin_flag;
    logic        last;
    logic [15:0] in_flight;
    logic [7:0]  retransmit_count;
    logic [15:0] accepted_bytes;

    modport source (output valid, kind, seqno, payload_length, stream_offset, syn_flag,
                    fin_flag, last, in_flight, retransmit_count, accepted_bytes,
                    input ready);
    modport sink   (input valid, kind, seqno, payload_length, stream_offset, syn_flag,
                    fin_flag, last, in_flight, retransmit_count, accepted_bytes,
                    output ready);
endinterface

// ===== rtl/core/tcp_sender_window_retransmit_core.sv =====
// top level: event sequencer of the tcp sender window/retransmit core
//
//  channel  | dir | handshake         | contents
//  in_ch    | in  | valid/ready       | op, byte_count, ackno, adv_window, elapsed_ms
//  out_ch   | out | valid/ready       | segment descriptor plus status, last marks end
//  cfg      | in  | cfg_we, no ready  | cfg_index 0 isn, 1 initial_rto
//
// one event at a time: end/empty/unknown go straight to the status result, a write
// updates the buffer first, a tick adds then compares the timer; an ack unwraps and
// compares, then reads, sums and checks each queue entry; a fill passes fill_a and
// fill_b per segment sent; each queued result takes a queue read, an output load
// and a transaction, then the sequencer returns to idle.
// in_ch.ready is low from acceptance until the final result is taken.
// out_ch stalls hold the output register; nothing else advances meanwhile.
// reset is asynchronous; the queue memory has no reset and needs no clearing.
module tcp_sender_window_retransmit_core #(
    parameter int MAX_PAYLOAD     = tswr_pkg::MAX_PAYLOAD_DEF,
    parameter int QUEUE_DEPTH     = tswr_pkg::QUEUE_DEPTH_DEF,
    parameter int STREAM_CAPACITY = tswr_pkg::STREAM_CAP_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    tswr_in_if.sink     in_ch,
    tswr_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import tswr_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [16:0] MAXP_C = 17'(MAX_PAYLOAD);
    localparam logic [16:0] CAP_C  = 17'(STREAM_CAPACITY);
    localparam logic [4:0]  MAXR_C = 5'(MAX_RESULTS);

    typedef enum logic [4:0] {
        S_IDLE, S_WRITE, S_UNWRAP, S_ACK_CMP, S_POP_RD, S_POP_SUM, S_POP_CHK,
        S_FILL_A, S_FILL_B, S_TICK_ADD, S_TICK_CMP, S_STAT, S_OUT_RD, S_OUT_LOAD,
        S_OUT_HOLD
    } state_t;

    state_t state_reg;

    // configuration
    logic [31:0] isn_reg;
    logic [15:0] init_rto_reg;

    // latched event
    logic [2:0]  op_reg;
    logic [15:0] bc_reg;
    logic [31:0] ackno_reg;
    logic [15:0] win_reg;
    logic [15:0] el_reg;

    // sender state
    logic [63:0]      next_reg, acked_reg, ack_abs_reg, end_reg;
    logic [16:0]      flight_reg, buffered_reg, seglen_reg, pay_reg, window_reg;
    logic [15:0]      peer_win_reg, accepted_reg;
    logic             syn_sent_reg, fin_sent_reg, ended_reg, syn_f_reg;
    logic [31:0]      timer_reg, rto_reg;
    logic [7:0]       retx_reg;
    logic [IDX_W-1:0] head_reg, out_idx_reg;
    logic [CNT_W-1:0] count_reg;
    logic [4:0]       k_reg, left_reg;
    logic [1:0]       out_kind_reg;

    // output register
    logic        ov_reg, olast_reg, osyn_reg, ofin_reg;
    logic [1:0]  okind_reg;
    logic [31:0] oseq_reg;
    logic [10:0] olen_reg;
    logic [63:0] ooff_reg;

    // queue memory
    logic             q_we;
    logic [IDX_W-1:0] q_waddr, q_raddr;
    qentry_t          q_wdata, q_rdata;

    tswr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk     (clk),
        .wr_en   (q_we),
        .wr_addr (q_waddr),
        .wr_data (q_wdata),
        .rd_addr (q_raddr),
        .rd_data (q_rdata)
    );

    // tail slot of the queue
    logic [IDX_W:0]   tail_sum;
    logic [IDX_W-1:0] tail_idx;
    assign tail_sum = {1'b0, head_reg} + (IDX_W+1)'(count_reg);
    assign tail_idx = (tail_sum >= (IDX_W+1)'(QUEUE_DEPTH))
                      ? IDX_W'(tail_sum - (IDX_W+1)'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

    logic [IDX_W-1:0] head_inc, out_inc;
    assign head_inc = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign out_inc  = (out_idx_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : out_idx_reg + 1'b1;

    assign q_raddr = (state_reg == S_OUT_RD) ? out_idx_reg : head_reg;

    // ack unwrap, 32-bit compares against the low half of next_seqno
    logic [31:0] uw_off, uw_lo, uw_hi;
    logic [63:0] uw_abs;
    always_comb
    begin
        uw_off = ackno_reg - isn_reg;
        uw_lo  = next_reg[31:0];
        uw_hi  = next_reg[63:32];
        uw_abs = {uw_hi, uw_off};
        if (uw_off > uw_lo && uw_hi != 32'd0 && (uw_off - uw_lo) > 32'h8000_0000)
        begin
            uw_abs = {uw_hi - 32'd1, uw_off};
        end
        else if (uw_off < uw_lo && (uw_lo - uw_off) > 32'h8000_0000
                 && uw_hi != 32'hFFFF_FFFF)
        begin
            uw_abs = {uw_hi + 32'd1, uw_off};
        end
    end

    // fill step first half: window, room, size cap
    logic [16:0] fa_window, fa_room, fa_cap;
    logic        fa_go, fa_syn;
    always_comb
    begin
        fa_window = (peer_win_reg == 16'd0) ? 17'd1 : {1'b0, peer_win_reg};
        fa_go     = flight_reg < fa_window && count_reg != DEPTH_C && k_reg < MAXR_C;
        fa_syn    = !syn_sent_reg;
        fa_room   = fa_window - flight_reg - {16'd0, fa_syn};
        fa_cap    = (fa_room < MAXP_C) ? fa_room : MAXP_C;
    end

    // fill step second half: payload, fin, length
    logic [16:0] fb_pay, fb_len;
    logic        fb_fin;
    always_comb
    begin
        fb_pay = (pay_reg > buffered_reg) ? buffered_reg : pay_reg;
        fb_fin = !fin_sent_reg && ended_reg && buffered_reg == fb_pay
                 && (fb_pay + flight_reg + {16'd0, syn_f_reg}) < window_reg;
        fb_len = fb_pay + {16'd0, syn_f_reg} + {16'd0, fb_fin};
    end

    assign q_we    = (state_reg == S_FILL_B) && fb_len != 17'd0;
    assign q_waddr = tail_idx;
    assign q_wdata = '{start: next_reg, len: fb_pay[10:0], syn: syn_f_reg, fin: fb_fin};

    // write acceptance
    logic [16:0] wr_space, wr_acc;
    assign wr_space = (buffered_reg < CAP_C) ? CAP_C - buffered_reg : 17'd0;
    assign wr_acc   = ({1'b0, bc_reg} < wr_space) ? {1'b0, bc_reg} : wr_space;

    // timer add, saturating
    logic [32:0] tk_sum;
    assign tk_sum = {1'b0, timer_reg} + {17'd0, el_reg};

    // descriptor fields from the queue entry
    logic [63:0] ld_off;
    assign ld_off = (q_rdata.len != 11'd0)
                    ? q_rdata.start + {63'd0, q_rdata.syn} - 64'd1 : 64'd0;

    // sequencer with state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            isn_reg      <= '0;
            init_rto_reg <= INIT_RTO_RESET;
            next_reg     <= '0;
            acked_reg    <= '0;
            flight_reg   <= '0;
            buffered_reg <= '0;
            peer_win_reg <= 16'd1;
            syn_sent_reg <= 1'b0;
            fin_sent_reg <= 1'b0;
            ended_reg    <= 1'b0;
            timer_reg    <= '0;
            rto_reg      <= {16'd0, INIT_RTO_RESET};
            retx_reg     <= '0;
            head_reg     <= '0;
            count_reg    <= '0;
            k_reg        <= '0;
            left_reg     <= '0;
            ov_reg       <= 1'b0;
            accepted_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ISN: isn_reg <= cfg_data;
                    CFG_RTO: init_rto_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        op_reg       <= in_ch.op;
                        bc_reg       <= in_ch.byte_count;
                        ackno_reg    <= in_ch.ackno;
                        win_reg      <= in_ch.adv_window;
                        el_reg       <= in_ch.elapsed_ms;
                        accepted_reg <= '0;
                        k_reg        <= '0;
                        unique case (in_ch.op)
                            OP_WRITE: state_reg <= S_WRITE;
                            OP_END:
                            begin
                                ended_reg <= 1'b1;
                                state_reg <= S_STAT;
                            end
                            OP_FILL:  state_reg <= S_FILL_A;
                            OP_ACK:   state_reg <= S_UNWRAP;
                            OP_TICK:  state_reg <= S_TICK_ADD;
                            default:  state_reg <= S_STAT;
                        endcase
                    end
                end
                S_WRITE:
                begin
                    if (!ended_reg)
                    begin
                        accepted_reg <= wr_acc[15:0];
                        buffered_reg <= buffered_reg + wr_acc;
                    end
                    state_reg <= S_STAT;
                end
                S_UNWRAP:
                begin
                    ack_abs_reg <= uw_abs;
                    state_reg   <= S_ACK_CMP;
                end
                S_ACK_CMP:
                begin
                    if (ack_abs_reg <= next_reg)
                    begin
                        acked_reg    <= ack_abs_reg;
                        retx_reg     <= '0;
                        peer_win_reg <= win_reg;
                        state_reg    <= (count_reg != '0) ? S_POP_RD : S_FILL_A;
                    end
                    else
                    begin
                        state_reg <= S_STAT;
                    end
                end
                S_POP_RD:
                begin
                    state_reg <= S_POP_SUM;
                end
                S_POP_SUM:
                begin
                    seglen_reg <= {6'd0, q_rdata.len} + {16'd0, q_rdata.syn}
                                  + {16'd0, q_rdata.fin};
                    end_reg    <= q_rdata.start + {53'd0, q_rdata.len}
                                  + {63'd0, q_rdata.syn} + {63'd0, q_rdata.fin};
                    state_reg  <= S_POP_CHK;
                end
                S_POP_CHK:
                begin
                    if (end_reg > acked_reg)
                    begin
                        state_reg <= S_FILL_A;
                    end
                    else
                    begin
                        flight_reg <= flight_reg - seglen_reg;
                        head_reg   <= head_inc;
                        count_reg  <= count_reg - 1'b1;
                        rto_reg    <= {16'd0, init_rto_reg};
                        timer_reg  <= '0;
                        state_reg  <= (count_reg == CNT_W'(1)) ? S_FILL_A : S_POP_RD;
                    end
                end
                S_FILL_A:
                begin
                    if (fa_go)
                    begin
                        syn_sent_reg <= 1'b1;
                        syn_f_reg    <= fa_syn;
                        if (count_reg == '0)
                        begin
                            rto_reg   <= {16'd0, init_rto_reg};
                            timer_reg <= '0;
                        end
                        if (k_reg == '0)
                        begin
                            out_idx_reg <= tail_idx;
                        end
                        window_reg <= fa_window;
                        pay_reg    <= fa_cap;
                        state_reg  <= S_FILL_B;
                    end
                    else if (k_reg != '0)
                    begin
                        out_kind_reg <= KIND_NEW;
                        left_reg     <= k_reg;
                        state_reg    <= S_OUT_RD;
                    end
                    else
                    begin
                        state_reg <= S_STAT;
                    end
                end
                S_FILL_B:
                begin
                    if (fb_len == 17'd0)
                    begin
                        if (k_reg != '0)
                        begin
                            out_kind_reg <= KIND_NEW;
                            left_reg     <= k_reg;
                            state_reg    <= S_OUT_RD;
                        end
                        else
                        begin
                            state_reg <= S_STAT;
                        end
                    end
                    else
                    begin
                        count_reg    <= count_reg + 1'b1;
                        buffered_reg <= buffered_reg - fb_pay;
                        flight_reg   <= flight_reg + fb_len;
                        next_reg     <= next_reg + {47'd0, fb_len};
                        k_reg        <= k_reg + 5'd1;
                        if (fb_fin)
                        begin
                            fin_sent_reg <= 1'b1;
                            out_kind_reg <= KIND_NEW;
                            left_reg     <= k_reg + 5'd1;
                            state_reg    <= S_OUT_RD;
                        end
                        else
                        begin
                            state_reg <= S_FILL_A;
                        end
                    end
                end
                S_TICK_ADD:
                begin
                    timer_reg <= tk_sum[32] ? 32'hFFFF_FFFF : tk_sum[31:0];
                    state_reg <= S_TICK_CMP;
                end
                S_TICK_CMP:
                begin
                    if (timer_reg >= rto_reg && count_reg != '0)
                    begin
                        if (retx_reg != 8'hFF)
                        begin
                            retx_reg <= retx_reg + 8'd1;
                        end
                        timer_reg <= '0;
                        if (peer_win_reg != 16'd0)
                        begin
                            rto_reg <= rto_reg[31] ? 32'hFFFF_FFFF : {rto_reg[30:0], 1'b0};
                        end
                        out_idx_reg  <= head_reg;
                        out_kind_reg <= KIND_RETX;
                        left_reg     <= 5'd1;
                        state_reg    <= S_OUT_RD;
                    end
                    else
                    begin
                        state_reg <= S_STAT;
                    end
                end
                S_STAT:
                begin
                    okind_reg <= (op_reg == OP_EMPTY) ? KIND_EMPTY : KIND_STATUS;
                    oseq_reg  <= next_reg[31:0] + isn_reg;
                    olen_reg  <= '0;
                    ooff_reg  <= '0;
                    osyn_reg  <= 1'b0;
                    ofin_reg  <= 1'b0;
                    olast_reg <= 1'b1;
                    ov_reg    <= 1'b1;
                    state_reg <= S_OUT_HOLD;
                end
                S_OUT_RD:
                begin
                    state_reg <= S_OUT_LOAD;
                end
                S_OUT_LOAD:
                begin
                    okind_reg <= out_kind_reg;
                    oseq_reg  <= q_rdata.start[31:0] + isn_reg;
                    olen_reg  <= q_rdata.len;
                    ooff_reg  <= ld_off;
                    osyn_reg  <= q_rdata.syn;
                    ofin_reg  <= q_rdata.fin;
                    olast_reg <= (left_reg == 5'd1);
                    ov_reg    <= 1'b1;
                    state_reg <= S_OUT_HOLD;
                end
                S_OUT_HOLD:
                begin
                    if (out_ch.ready)
                    begin
                        ov_reg <= 1'b0;
                        if (olast_reg)
                        begin
                            state_reg <= S_IDLE;
                        end
                        else
                        begin
                            out_idx_reg <= out_inc;
                            left_reg    <= left_reg - 5'd1;
                            state_reg   <= S_OUT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // channel outputs
    assign in_ch.ready             = (state_reg == S_IDLE);
    assign out_ch.valid            = ov_reg;
    assign out_ch.kind             = okind_reg;
    assign out_ch.seqno            = oseq_reg;
    assign out_ch.payload_length   = olen_reg;
    assign out_ch.stream_offset    = ooff_reg;
    assign out_ch.syn_flag         = osyn_reg;
    assign out_ch.fin_flag         = ofin_reg;
    assign out_ch.last             = olast_reg;
    assign out_ch.in_flight        = flight_reg[16] ? 16'hFFFF : flight_reg[15:0];
    assign out_ch.retransmit_count = retx_reg;
    assign out_ch.accepted_bytes   = accepted_reg;

endmodule

// ===== rtl/core/tswr_queue.sv =====
// outstanding segment queue storage, one write and one registered read port
module tswr_queue #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  tswr_pkg::qentry_t        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output tswr_pkg::qentry_t        rd_data
);
    import tswr_pkg::*;

    qentry_t mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/tswr_checker.sv =====
// port-level checks of the tcp sender core, bound to the top level
module tswr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  out_kind,
    input logic [10:0] out_len,
    input logic        out_syn,
    input logic        out_fin,
    input logic        out_last
);
    import tswr_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_last))
        else $error("stalled result changed");

    // no new transaction while a result is pending
    a_busy_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input ready while result pending");

    // an accepted event makes the block busy
    a_busy_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after acceptance");

    // status and empty results carry no segment
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == KIND_STATUS || out_kind == KIND_EMPTY)
        |-> out_len == 11'd0 && !out_syn && !out_fin && out_last)
        else $error("status result with segment fields");

endmodule

bind tcp_sender_window_retransmit_core tswr_checker u_tswr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_len   (out_ch.payload_length),
    .out_syn   (out_ch.syn_flag),
    .out_fin   (out_ch.fin_flag),
    .out_last  (out_ch.last)
);

// ===== tb/tb_tcp_sender_window_retransmit_core.sv =====
// self-checking testbench of the tcp sender window/retransmit core
module tb_tcp_sender_window_retransmit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import tswr_pkg::*;

    localparam int SEG_MAX   = 1452;
    localparam int QDEPTH    = 16;
    localparam int STREAM_CAP = 65536;
    localparam int STALL_LIMIT = 6000;

    // op codes outside the defined set
    localparam logic [2:0] OP_RSVD_A = 3'd6;
    localparam logic [2:0] OP_RSVD_B = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] byte_count;
        logic [31:0] ackno;
        logic [15:0] adv_window;
        logic [15:0] elapsed_ms;
    } event_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seqno;
        logic [10:0] payload_length;
        logic [63:0] stream_offset;
        logic        syn_flag;
        logic        fin_flag;
        logic        last;
        logic [15:0] in_flight;
        logic [7:0]  retransmit_count;
        logic [15:0] accepted_bytes;
    } seg_desc_t;

    // sender-side predictor and store of expected descriptors
    class sender_scoreboard;
        bit [31:0] isn;
        bit [15:0] init_rto;
        bit [63:0] next_seq, acked_seq, read_total;
        bit [31:0] flight, buffered, timer, rto;
        bit [15:0] peer_win;
        bit        syn_done, fin_done, ended;
        bit [7:0]  retx;
        bit [63:0] q_start [QDEPTH];
        bit [10:0] q_len [QDEPTH];
        bit        q_syn [QDEPTH];
        bit        q_fin [QDEPTH];
        int        q_head, q_cnt;
        seg_desc_t pending [$];
        seg_desc_t batch [$];
        int        errors;

        function new();
            isn = 0;
            init_rto = INIT_RTO_RESET;
            next_seq = 0; acked_seq = 0; read_total = 0;
            flight = 0; buffered = 0; timer = 0;
            rto = 32'(INIT_RTO_RESET);
            peer_win = 1;
            syn_done = 0; fin_done = 0; ended = 0;
            retx = 0;
            q_head = 0; q_cnt = 0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            if (idx == CFG_ISN) isn = val;
            else if (idx == CFG_RTO) init_rto = val[15:0];
        endfunction

        function bit [31:0] wrap(bit [63:0] a);
            return a[31:0] + isn;
        endfunction

        // nearest absolute seqno to the checkpoint
        function bit [63:0] unwrap(bit [31:0] w, bit [63:0] cp);
            bit [31:0] off;
            bit [63:0] t;
            off = w - isn;
            t = {cp[63:32], off};
            if (t > cp && t >= 64'h1_0000_0000 && t - cp > 64'h8000_0000)
                t = t - 64'h1_0000_0000;
            else if (t < cp && cp - t > 64'h8000_0000 && t <= 64'hFFFF_FFFE_FFFF_FFFF)
                t = t + 64'h1_0000_0000;
            return t;
        endfunction

        function void add_desc(logic [1:0] kind, bit [31:0] seq, bit [10:0] len,
                               bit [63:0] off, bit syn, bit fin);
            seg_desc_t d;
            d = '0;
            d.kind = kind; d.seqno = seq; d.payload_length = len;
            d.stream_offset = off; d.syn_flag = syn; d.fin_flag = fin;
            batch.push_back(d);
        endfunction

        function void add_queued(logic [1:0] kind, int idx);
            bit [63:0] off;
            off = (q_len[idx] != 0) ? q_start[idx] + q_syn[idx] - 64'd1 : 64'd0;
            add_desc(kind, wrap(q_start[idx]), q_len[idx], off, q_syn[idx], q_fin[idx]);
        endfunction

        // send whatever the window allows
        function void send_segments();
            bit [63:0] win, room, seg_total;
            bit [31:0] pay;
            bit syn, fin;
            int idx;
            win = (peer_win != 0) ? 64'(peer_win) : 64'd1;
            while (flight < win && q_cnt < QDEPTH && batch.size() < MAX_RESULTS) begin
                syn = 0; fin = 0;
                if (!syn_done) begin syn_done = 1; syn = 1; end
                if (q_cnt == 0) begin rto = 32'(init_rto); timer = 0; end
                room = win - flight;
                room = (room >= syn) ? room - syn : 64'd0;
                pay = (room < SEG_MAX) ? room[31:0] : SEG_MAX;
                if (pay > buffered) pay = buffered;
                if (!fin_done && ended && buffered == pay &&
                    64'(pay) + flight + syn < win) begin
                    fin_done = 1;
                    fin = 1;
                end
                seg_total = 64'(syn) + pay + fin;
                if (seg_total == 0) break;
                idx = (q_head + q_cnt) % QDEPTH;
                q_start[idx] = next_seq;
                q_len[idx] = pay[10:0];
                q_syn[idx] = syn;
                q_fin[idx] = fin;
                q_cnt++;
                buffered -= pay;
                read_total += pay;
                add_queued(KIND_NEW, idx);
                flight += seg_total[31:0];
                next_seq += seg_total;
                if (fin) break;
            end
        endfunction

        // accepted event: predict every descriptor it causes
        function void note_event(event_t ev);
            bit [31:0] accepted, space;
            bit [63:0] a, seg_total;
            accepted = 0;
            batch.delete();
            case (ev.op)
                OP_WRITE: begin
                    if (!ended) begin
                        space = (buffered < STREAM_CAP) ? STREAM_CAP - buffered : 0;
                        accepted = (32'(ev.byte_count) < space) ? 32'(ev.byte_count) : space;
                        buffered += accepted;
                    end
                end
                OP_END: ended = 1;
                OP_FILL: send_segments();
                OP_ACK: begin
                    a = unwrap(ev.ackno, next_seq);
                    if (a <= next_seq) begin
                        acked_seq = a;
                        while (q_cnt > 0) begin
                            seg_total = 64'(q_len[q_head]) + q_syn[q_head] + q_fin[q_head];
                            if (q_start[q_head] + seg_total > acked_seq) break;
                            flight -= seg_total[31:0];
                            q_head = (q_head + 1) % QDEPTH;
                            q_cnt--;
                            rto = 32'(init_rto);
                            timer = 0;
                        end
                        retx = 0;
                        peer_win = ev.adv_window;
                        send_segments();
                    end
                end
                OP_TICK: begin
                    timer = (timer > 32'hFFFF_FFFF - ev.elapsed_ms) ? 32'hFFFF_FFFF
                                                                    : timer + ev.elapsed_ms;
                    if (timer >= rto && q_cnt > 0) begin
                        add_queued(KIND_RETX, q_head);
                        if (retx < 8'd255) retx++;
                        timer = 0;
                        if (peer_win > 0)
                            rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto * 2;
                    end
                end
                OP_EMPTY: add_desc(KIND_EMPTY, wrap(next_seq), '0, '0, 1'b0, 1'b0);
                default: ;
            endcase
            if (batch.size() == 0) add_desc(KIND_STATUS, wrap(next_seq), '0, '0, 1'b0, 1'b0);
            foreach (batch[i]) begin
                batch[i].last = (i == batch.size() - 1);
                batch[i].in_flight = (flight > 32'hFFFF) ? 16'hFFFF : flight[15:0];
                batch[i].retransmit_count = retx;
                batch[i].accepted_bytes = accepted[15:0];
                pending.push_back(batch[i]);
            end
        endfunction

        function void check_desc(seg_desc_t act);
            seg_desc_t exp_d;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected descriptor kind %0d seq %h",
                                           act.kind, act.seqno);
                return;
            end
            exp_d = pending.pop_front();
            if (act !== exp_d) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: k%0d seq %h len %0d off %h s%0d f%0d l%0d fl %0d rx %0d acc %0d",
                             exp_d.kind, exp_d.seqno, exp_d.payload_length,
                             exp_d.stream_offset, exp_d.syn_flag, exp_d.fin_flag, exp_d.last,
                             exp_d.in_flight, exp_d.retransmit_count, exp_d.accepted_bytes);
                    $display("         act: k%0d seq %h len %0d off %h s%0d f%0d l%0d fl %0d rx %0d acc %0d",
                             act.kind, act.seqno, act.payload_length,
                             act.stream_offset, act.syn_flag, act.fin_flag, act.last,
                             act.in_flight, act.retransmit_count, act.accepted_bytes);
                end
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    tswr_in_if  in_ch ();
    tswr_out_if out_ch ();

    tcp_sender_window_retransmit_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sender_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req = 0;
    bit  allow_end = 0;
    int  stall_cycles = 0;

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 0;
        in_ch.op = '0;
        in_ch.byte_count = '0;
        in_ch.ackno = '0;
        in_ch.adv_window = '0;
        in_ch.elapsed_ms = '0;
        out_ch.ready = 0;
    end

    // receiver: random back-pressure plus one long hold-off on request
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = 400;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // check every descriptor transaction
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_desc({out_ch.kind, out_ch.seqno, out_ch.payload_length,
                           out_ch.stream_offset, out_ch.syn_flag, out_ch.fin_flag,
                           out_ch.last, out_ch.in_flight, out_ch.retransmit_count,
                           out_ch.accepted_bytes});
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_event(event_t ev);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid <= 1'b1;
        in_ch.op <= ev.op;
        in_ch.byte_count <= ev.byte_count;
        in_ch.ackno <= ev.ackno;
        in_ch.adv_window <= ev.adv_window;
        in_ch.elapsed_ms <= ev.elapsed_ms;
        do @(posedge clk); while (!in_ch.ready);
        sb.note_event(ev);
    endtask

    task automatic send_op(logic [2:0] op, logic [15:0] cnt, logic [31:0] ack,
                           logic [15:0] win, logic [15:0] ms);
        send_event({op, cnt, ack, win, ms});
    endtask

    // write a register once everything has drained
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    // ackno somewhere between the acked point and next seqno
    function automatic logic [31:0] fair_ack();
        bit [63:0] span;
        span = sb.next_seq - sb.acked_seq;
        return sb.wrap(sb.acked_seq + $urandom_range(span[31:0], 0));
    endfunction

    function automatic event_t random_event();
        event_t ev;
        logic [95:0] raw;
        int pick;
        raw = {$urandom, $urandom, $urandom};
        ev = raw[$bits(event_t)-1:0];
        pick = $urandom_range(99);
        if (pick < 20)
        begin
            ev.op = OP_WRITE;
            if ($urandom_range(9) == 0) ev.byte_count = 16'hFFFF;
            else ev.byte_count = 16'($urandom_range(3000));
        end
        else if (pick < 44) ev.op = OP_FILL;
        else if (pick < 74)
        begin
            ev.op = OP_ACK;
            if ($urandom_range(9) != 0) ev.ackno = fair_ack();
            case ($urandom_range(9))
                0: ev.adv_window = '0;
                1: ev.adv_window = 16'hFFFF;
                2, 3: ev.adv_window = 16'($urandom_range(100));
                default: ev.adv_window = 16'($urandom_range(30000));
            endcase
        end
        else if (pick < 90)
        begin
            ev.op = OP_TICK;
            if ($urandom_range(9) == 0) ev.elapsed_ms = 16'hFFFF;
            else ev.elapsed_ms = 16'($urandom_range(2000));
        end
        else if (pick < 94) ev.op = OP_EMPTY;
        else if (pick < 97) ev.op = ($urandom_range(1) != 0) ? OP_RSVD_A : OP_RSVD_B;
        else ev.op = allow_end ? OP_END : OP_FILL;
        return ev;
    endfunction

    task automatic random_run(int n);
        repeat (n) send_event(random_event());
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // phase one: seqno wrap near the top of the space
        write_reg(CFG_ISN, 32'hFFFF_FFF0);
        write_reg(CFG_RTO, 32'd1000);
        tx_idle_pct = 17;
        rx_idle_pct = 66;

        // directed: syn, zero window, capacity, queue full, retransmit, bad ack
        send_op(OP_FILL, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_ACK, 16'd0, sb.wrap(sb.next_seq), 16'd0, 16'd0);
        send_op(OP_WRITE, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_op(OP_WRITE, 16'hFFFF, 32'd0, 16'd0, 16'd0);
        send_op(OP_WRITE, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_FILL, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_TICK, 16'd0, 32'd0, 16'd0, 16'd999);
        send_op(OP_TICK, 16'd0, 32'd0, 16'd0, 16'hFFFF);
        send_op(OP_ACK, 16'd0, sb.wrap(sb.next_seq), 16'hFFFF, 16'd0);
        send_op(OP_FILL, 16'd0, 32'd0, 16'hFFFF, 16'd0);
        send_op(OP_TICK, 16'd0, 32'd0, 16'd0, 16'hFFFF);
        send_op(OP_TICK, 16'd0, 32'd0, 16'd0, 16'hFFFF);
        send_op(OP_TICK, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_ACK, 16'd0, sb.wrap(sb.next_seq + 64'd1000), 16'd500, 16'd0);
        send_op(OP_RSVD_A, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        send_op(OP_RSVD_B, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_EMPTY, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_ACK, 16'd0, fair_ack(), 16'd3000, 16'd0);
        send_op(OP_ACK, 16'd0, sb.wrap(sb.next_seq), 16'd0, 16'd0);
        send_op(OP_TICK, 16'd0, 32'd0, 16'd0, 16'hFFFF);
        random_run(130);

        // phase two: zero rto, long receiver hold-off
        write_reg(CFG_ISN, 32'd0);
        write_reg(CFG_RTO, 32'd0);
        tx_idle_pct = 66;
        rx_idle_pct = 17;
        random_run(30);
        hold_req = 1;
        random_run(110);

        // phase three: extreme settings, input ends along the way
        write_reg(CFG_ISN, 32'hFFFF_FFFF);
        write_reg(CFG_RTO, 32'd65535);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_run(90);
        send_op(OP_END, 16'd0, 32'd0, 16'd0, 16'd0);
        send_op(OP_WRITE, 16'd100, 32'd0, 16'd0, 16'd0);
        send_op(OP_ACK, 16'd0, sb.wrap(sb.next_seq), 16'd700, 16'd0);
        send_op(OP_ACK, 16'd0, sb.wrap(sb.next_seq), 16'hFFFF, 16'd0);
        send_op(OP_FILL, 16'd0, 32'd0, 16'd0, 16'd0);
        allow_end = 1;
        random_run(50);

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
